// ===== design/mmc_pkg.sv =====
// shared types, constants and microcode table for the mandelbrot membership counter
package mmc_pkg;

  localparam int FRAC_BITS = 28;
  localparam int MAX_RESOLUTION = 1024;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W = 23;
  localparam int ITER_W = 16;
  localparam int OFF_W = 12;
  localparam int MUL_W = 33;
  localparam int PROD_W = 64;
  localparam int ZW = 38;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_RE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_IM = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 3'd4;

  localparam logic [30:0] STEP_SIZE_RST = 31'd524288;
  localparam logic [ITER_W-1:0] MAX_ITERS_RST = 16'd1000;
  localparam logic [30:0] THRESHOLD_RST = 31'd536870912;

  localparam logic signed [OFF_W-1:0] OFF_HI = OFF_W'(MAX_RESOLUTION);
  localparam logic signed [OFF_W-1:0] OFF_LO = OFF_W'(-MAX_RESOLUTION);
  localparam logic signed [PROD_W-1:0] COORD_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] COORD_MIN = -64'sd2147483648;
  localparam logic signed [ZW-1:0] MAG_HI = 38'sd2147483648;
  localparam logic signed [ZW-1:0] MAG_LO = -38'sd2147483648;

  // sequencer steps
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMUL = 3'd1;
  localparam logic [2:0] ST_CADD = 3'd2;
  localparam logic [2:0] ST_IMUL = 3'd3;
  localparam logic [2:0] ST_IUPD = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  // hold conditions: stay on the current step while true
  localparam logic [1:0] H_NONE = 2'd0;
  localparam logic [1:0] H_NO_INPUT = 2'd1;
  localparam logic [1:0] H_OUT_BUSY = 2'd2;

  // jump conditions: go to the target step while true
  localparam logic [1:0] J_NONE = 2'd0;
  localparam logic [1:0] J_ALWAYS = 2'd1;
  localparam logic [1:0] J_ITER_MORE = 2'd2;

  typedef struct packed {
    logic signed [OFF_W-1:0] col_offset;
    logic signed [OFF_W-1:0] row_offset;
    logic                    last_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic               in_set;
    logic [COUNT_W-1:0] set_count;
    logic               image_done;
  } result_t;

  typedef struct packed {
    logic       in_take;
    logic       mul_orbit;
    logic       coord_ld;
    logic       iter_upd;
    logic       result_ld;
    logic [1:0] hold_sel;
    logic [1:0] jump_sel;
    logic [2:0] target;
  } uword_t;

  // microprogram: one control word per step
  function automatic uword_t ucode(input logic [2:0] step);
    uword_t w;
    w = '0;
    unique case (step)
      ST_IDLE: begin
        w.in_take = 1'b1;
        w.hold_sel = H_NO_INPUT;
      end
      ST_CMUL: begin
        w.mul_orbit = 1'b0;
      end
      ST_CADD: begin
        w.coord_ld = 1'b1;
      end
      ST_IMUL: begin
        w.mul_orbit = 1'b1;
      end
      ST_IUPD: begin
        w.mul_orbit = 1'b1;
        w.iter_upd = 1'b1;
        w.jump_sel = J_ITER_MORE;
        w.target = ST_IMUL;
      end
      ST_DONE: begin
        w.result_ld = 1'b1;
        w.hold_sel = H_OUT_BUSY;
        w.jump_sel = J_ALWAYS;
        w.target = ST_IDLE;
      end
      default: begin
        w.jump_sel = J_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [OFF_W-1:0] v);
    logic signed [OFF_W-1:0] r;
    r = v;
    if (v > OFF_HI) r = OFF_HI;
    else if (v < OFF_LO) r = OFF_LO;
    return r;
  endfunction

  function automatic logic signed [31:0] sat_coord(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    r = 32'(v);
    if (v > COORD_MAX) r = 32'sh7fffffff;
    else if (v < COORD_MIN) r = 32'sh80000000;
    return r;
  endfunction

endpackage

// ===== design/mandelbrot_membership_counter.sv =====
// mandelbrot escape-time membership counter, microcoded over three shared multipliers
//
//  channel | signals                       | moves
//  in      | in_valid in_ready in_data     | one pixel (col, row offsets, last mark)
//  out     | out_valid out_ready out_data  | in-set flag, running count, image done
//  cfg     | cfg_we cfg_index cfg_data     | register write, no wait
//
// a pixel reaches the output register through the coordinate multiply and add steps, then n pairs
// of squaring and update steps, then the result step; n is the iterations run, max_iters + 1 for a point in the set;
// each iteration is one squaring step and one update step through the three multipliers, which sets the rate
// one pixel is worked at a time; a new pixel is taken while a result waits in the
// output register, and the result step holds until that register is free
// rst is synchronous: configuration, sequencer step and output valid return to their reset values, count cleared
module mandelbrot_membership_counter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mmc_pkg::pixel_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mmc_pkg::result_t                     out_data,
  input  logic                                 cfg_we,
  input  logic [mmc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mmc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // configuration
  logic signed [31:0]               center_re;
  logic signed [31:0]               center_im;
  logic [30:0]                      step_size;
  logic [mmc_pkg::ITER_W-1:0]       max_iters;
  logic [30:0]                      threshold;

  // sequencer
  logic [2:0]                       pc;
  logic [2:0]                       pc_next;
  mmc_pkg::uword_t                  uw;
  logic                             hold;
  logic                             jump;

  // datapath
  logic signed [mmc_pkg::OFF_W-1:0] col;
  logic signed [mmc_pkg::OFF_W-1:0] row;
  logic                             last;
  logic signed [31:0]               cr;
  logic signed [31:0]               ci;
  logic signed [31:0]               zr;
  logic signed [31:0]               zi;
  logic [mmc_pkg::PROD_W-1:0]       t2;
  logic [mmc_pkg::ITER_W-1:0]       iter;
  logic                             member;
  logic [mmc_pkg::COUNT_W-1:0]      pixel_count;

  logic signed [mmc_pkg::MUL_W-1:0] m_a0, m_b0, m_a1, m_b1, m_a2, m_b2;
  logic signed [mmc_pkg::PROD_W-1:0] mul0, mul1, mul2;
  logic signed [mmc_pkg::PROD_W-1:0] p0, p1, p2;
  logic signed [mmc_pkg::PROD_W-1:0] diff;
  logic [mmc_pkg::PROD_W-1:0]       mag;
  logic signed [mmc_pkg::ZW-1:0]    nr;
  logic signed [mmc_pkg::ZW-1:0]    ni;
  logic                             mag_esc;
  logic                             at_limit;
  logic                             bound_esc;
  logic                             loop_exit;
  logic                             result_go;
  logic [mmc_pkg::COUNT_W-1:0]      set_val;

  assign uw = mmc_pkg::ucode(pc);
  assign in_ready = uw.in_take;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_re <= '0;
      center_im <= '0;
      step_size <= mmc_pkg::STEP_SIZE_RST;
      max_iters <= mmc_pkg::MAX_ITERS_RST;
      threshold <= mmc_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mmc_pkg::REG_CENTER_RE: center_re <= $signed(cfg_data);
        mmc_pkg::REG_CENTER_IM: center_im <= $signed(cfg_data);
        mmc_pkg::REG_STEP_SIZE: step_size <= cfg_data[30:0];
        mmc_pkg::REG_MAX_ITERS: max_iters <= cfg_data[mmc_pkg::ITER_W-1:0];
        mmc_pkg::REG_THRESHOLD: threshold <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // sequencer condition decode
  always_comb begin
    unique case (uw.hold_sel)
      mmc_pkg::H_NO_INPUT: hold = !in_valid;
      mmc_pkg::H_OUT_BUSY: hold = out_valid && !out_ready;
      default:             hold = 1'b0;
    endcase
    unique case (uw.jump_sel)
      mmc_pkg::J_ALWAYS:    jump = 1'b1;
      mmc_pkg::J_ITER_MORE: jump = !loop_exit;
      default:              jump = 1'b0;
    endcase
    if (hold) pc_next = pc;
    else if (jump) pc_next = uw.target;
    else pc_next = pc + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mmc_pkg::ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // multiplier operands: pixel coordinates and threshold square, or the orbit squares and cross product
  always_comb begin
    if (uw.mul_orbit) begin
      m_a0 = 33'(zr);
      m_b0 = 33'(zr);
      m_a1 = 33'(zi);
      m_b1 = 33'(zi);
      m_a2 = 33'(zr);
      m_b2 = 33'(zi);
    end else begin
      m_a0 = 33'(col);
      m_b0 = $signed({2'b00, step_size});
      m_a1 = 33'(row);
      m_b1 = $signed({2'b00, step_size});
      m_a2 = $signed({2'b00, threshold});
      m_b2 = $signed({2'b00, threshold});
    end
  end

  assign mul0 = mmc_pkg::PROD_W'(m_a0) * mmc_pkg::PROD_W'(m_b0);
  assign mul1 = mmc_pkg::PROD_W'(m_a1) * mmc_pkg::PROD_W'(m_b1);
  assign mul2 = mmc_pkg::PROD_W'(m_a2) * mmc_pkg::PROD_W'(m_b2);

  always_ff @(posedge clk) begin
    p0 <= mul0;
    p1 <= mul1;
    p2 <= mul2;
  end

  // iteration update from registered products of the current z
  assign diff = p0 - p1;
  assign mag = p0 + p1;
  assign nr = mmc_pkg::ZW'(diff >>> mmc_pkg::FRAC_BITS) + mmc_pkg::ZW'(cr);
  assign ni = mmc_pkg::ZW'(p2 >>> (mmc_pkg::FRAC_BITS - 1)) + mmc_pkg::ZW'(ci);
  assign mag_esc = (iter != '0) && (mag >= t2);
  assign at_limit = iter == max_iters;
  assign bound_esc = nr >= mmc_pkg::MAG_HI || nr <= mmc_pkg::MAG_LO
                  || ni >= mmc_pkg::MAG_HI || ni <= mmc_pkg::MAG_LO;
  assign loop_exit = mag_esc || at_limit || bound_esc;

  always_ff @(posedge clk) begin
    if (in_valid && uw.in_take) begin
      col <= mmc_pkg::sat_off(in_data.col_offset);
      row <= mmc_pkg::sat_off(in_data.row_offset);
      last <= in_data.last_pixel;
    end
    if (uw.coord_ld) begin
      cr <= mmc_pkg::sat_coord(mmc_pkg::PROD_W'(center_re) + p0);
      ci <= mmc_pkg::sat_coord(mmc_pkg::PROD_W'(center_im) + p1);
      t2 <= p2;
      zr <= '0;
      zi <= '0;
      iter <= '0;
    end
    if (uw.iter_upd) begin
      if (loop_exit) begin
        member <= !mag_esc && at_limit;
      end else begin
        zr <= nr[31:0];
        zi <= ni[31:0];
        iter <= iter + 16'd1;
      end
    end
  end

  // result and running count
  assign result_go = uw.result_ld && !hold;
  assign set_val = pixel_count + ((member && pixel_count != '1) ? 23'd1 : 23'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pixel_count <= '0;
    end else begin
      if (result_go) begin
        out_valid <= 1'b1;
        pixel_count <= last ? '0 : set_val;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_go) begin
      out_data.in_set <= member;
      out_data.set_count <= set_val;
      out_data.image_done <= last;
    end
  end

  // a taken pixel goes straight to the coordinate multiply
  a_take_to_cmul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> pc == mmc_pkg::ST_CMUL)
    else $error("pixel transfer did not start the coordinate step");

  // a new result only comes from the result step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pc) == mmc_pkg::ST_DONE)
    else $error("result appeared outside the result step");

  // iteration count never passes the limit
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (pc == mmc_pkg::ST_IMUL || pc == mmc_pkg::ST_IUPD) |-> iter <= max_iters)
    else $error("iteration count beyond max_iters");

  // the count starts over after the last pixel of an image
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (result_go && last) |=> pixel_count == '0)
    else $error("count not cleared after last pixel");

endmodule
